// File: design/hashed_lru_buffer_cache_assert.svh
// ----------------------------------------------------------------------------
// hashed_lru_buffer_cache assertion macros
// Concurrent assertion wrappers; they compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef HASHED_LRU_BUFFER_CACHE_ASSERT_SVH
`define HASHED_LRU_BUFFER_CACHE_ASSERT_SVH

`ifndef SYNTH
// clocked check, off while reset is high
`define HLBC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("hlbc assertion failed");
// clocked check that also runs through reset
`define HLBC_ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("hlbc assertion failed");
`else
`define HLBC_ASSERT(lbl, clk, rst, prop)
`define HLBC_ASSERT_CLK(lbl, clk, prop)
`endif

`endif

// File: design/hlbc_pkg.sv
// ----------------------------------------------------------------------------
// hlbc_pkg
// Types, codes and defaults of the hashed LRU buffer cache directory.
// ----------------------------------------------------------------------------
package hlbc_pkg;

  localparam int BUCKETS_DEFAULT = 16;
  localparam int WAYS_DEFAULT    = 4;

  localparam logic [7:0]  COUNT_MAX = 8'hff;
  localparam logic [31:0] TIME_MAX  = 32'hffff_ffff;

  typedef enum logic [1:0] {
    CMD_GET     = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_PIN     = 2'd2,
    CMD_UNPIN   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NO_FREE   = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic        entry_used;
    logic        data_valid;
    logic [7:0]  tag_device;
    logic [31:0] tag_block;
    logic [7:0]  ref_count;
    logic [31:0] last_use;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_EV,
    ST_FIN
  } state_t;

endpackage

// File: design/hlbc_entry_ram.sv
// ----------------------------------------------------------------------------
// hlbc_entry_ram
// Directory entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hlbc_entry_ram #(
  parameter int DEPTH = hlbc_pkg::BUCKETS_DEFAULT * hlbc_pkg::WAYS_DEFAULT,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  hlbc_pkg::entry_t wdata,
  input  logic [AW-1:0]    raddr,
  output hlbc_pkg::entry_t rdata
);

  hlbc_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: design/hlbc_bucket_div.sv
// ----------------------------------------------------------------------------
// hlbc_bucket_div
// Bucket index = block number mod BUCKETS: a mask for a power of two, else
// a registered reciprocal multiply and one conditional subtract.
// ----------------------------------------------------------------------------
module hlbc_bucket_div #(
  parameter int BUCKETS = hlbc_pkg::BUCKETS_DEFAULT,
  localparam int BW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [31:0]   dividend,
  output logic          done,
  output logic [BW-1:0] remainder
);

  localparam bit IS_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;
  // floor(2^32 / BUCKETS): the quotient estimate is exact or one low, so the
  // partial remainder stays below 2*BUCKETS and fits in BW+1 bits
  localparam logic [31:0] RECIP =
    (BUCKETS > 1) ? 32'((64'd1 << 32) / 64'(BUCKETS)) : 32'd0;
  localparam logic [BW:0] DIVISOR = (BW+1)'(BUCKETS);

  logic          busy;
  logic [63:0]   product;
  logic [BW:0]   low_bits;
  logic [BW:0]   quot_low;
  logic [BW:0]   partial;
  logic          partial_ge;
  logic [BW:0]   partial_sub;
  logic [BW-1:0] rem_next;

  // only the low bits of x - q*B are needed, the result is below 2^(BW+1)
  assign quot_low    = product[32 +: BW+1];
  assign partial     = low_bits - quot_low * DIVISOR;
  assign partial_ge  = partial >= DIVISOR;
  assign partial_sub = partial - DIVISOR;
  assign rem_next    = partial_ge ? partial_sub[BW-1:0] : partial[BW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        busy <= !IS_POW2;
        done <= IS_POW2;
      end else begin
        busy <= 1'b0;
        done <= busy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      product  <= 64'(dividend) * 64'(RECIP);
      low_bits <= dividend[BW:0];
      if (IS_POW2) begin
        remainder <= (BUCKETS == 1) ? '0 : dividend[BW-1:0];
      end
    end else if (busy) begin
      remainder <= rem_next;
    end
  end

endmodule

// File: design/hashed_lru_buffer_cache.sv
// ----------------------------------------------------------------------------
// hashed_lru_buffer_cache
// Set-associative block-buffer directory with reference counts and LRU reuse.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carry one command transaction (command,
// device, block_number, way, now). Output channel: out_valid/out_stall carry
// one result transaction (status, hit, bucket, slot, needs_fill) per command.
// One command is worked on at a time; in_stall is high while it runs.
// From accept to out_valid: ST_DIV waits on the bucket remainder unit (a
// mask when BUCKETS is a power of two, else a registered multiply), then
//   get             ST_RD/ST_EV per way up to the hit, all WAYS on a miss
//   release/pin/unp ST_RD/ST_EV once, or neither when way is beyond WAYS
// and ST_FIN loads the output register; the next command is taken in the
// ST_IDLE that follows. The ST_RD/ST_EV pair per way is the entry store
// read and the shared tag/age compare. The result sits in an output
// register, so a stalled receiver holds only that register while the next
// command runs; a second finished result waits until the register is
// taken.
// After reset the store is cleared one entry per cycle, all BUCKETS*WAYS
// entries, with in_stall high; out_valid is low from reset on.
// ----------------------------------------------------------------------------
`include "hashed_lru_buffer_cache_assert.svh"

module hashed_lru_buffer_cache #(
  parameter int BUCKETS = hlbc_pkg::BUCKETS_DEFAULT,
  parameter int WAYS    = hlbc_pkg::WAYS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [7:0]  device,
  input  logic [31:0] block_number,
  input  logic [1:0]  way,
  input  logic [31:0] now,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic        hit,
  output logic [3:0]  bucket,
  output logic [1:0]  slot,
  output logic        needs_fill
);

  localparam int ENTRIES = BUCKETS * WAYS;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WW      = (WAYS > 1) ? $clog2(WAYS) : 1;

  hlbc_pkg::state_t  state, state_next;

  hlbc_pkg::cmd_t    cmd_r;
  logic [7:0]        dev_r;
  logic [31:0]       blk_r;
  logic [1:0]        way_r;
  logic [31:0]       now_r;

  logic [AW-1:0]     clr_addr;
  logic [WW-1:0]     w_cnt;
  logic              found;
  logic [WW-1:0]     best_w;
  logic [31:0]       best_time;

  hlbc_pkg::status_t res_status;
  logic              res_hit;
  logic [1:0]        res_slot;
  logic              res_fill;

  logic              accept;
  logic              out_load;
  logic              div_start;
  logic              div_done;
  logic [BW-1:0]     bkt;
  logic              oor;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  hlbc_pkg::entry_t  ram_wdata;
  logic [AW-1:0]     ram_raddr;
  hlbc_pkg::entry_t  ram_rdata;

  logic              rd_hit;
  logic              cand;
  logic              last;
  logic              fin_found;
  logic [WW-1:0]     fin_w;
  logic [7:0]        cnt_up;
  logic              ev_finish;
  logic              ev_we;
  logic [AW-1:0]     ev_waddr;
  hlbc_pkg::entry_t  ev_wdata;
  hlbc_pkg::status_t ev_status;
  logic              ev_hit;
  logic [1:0]        ev_slot;
  logic              ev_fill;

  hlbc_entry_ram #(
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // started at the accepting edge, so it takes the block number off the port
  hlbc_bucket_div #(
    .BUCKETS (BUCKETS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (block_number),
    .done      (div_done),
    .remainder (bkt)
  );

  assign accept = in_valid && !in_stall;
  assign oor    = (cmd_r != hlbc_pkg::CMD_GET) && (5'(way_r) >= 5'(WAYS));

  // entry evaluation: tag match, age compare, count update
  always_comb begin
    rd_hit    = ram_rdata.entry_used && ram_rdata.tag_device == dev_r &&
                ram_rdata.tag_block == blk_r;
    cand      = ram_rdata.ref_count == 8'd0 &&
                (!found || ram_rdata.last_use < best_time);
    last      = w_cnt == WW'(WAYS - 1);
    fin_found = found || cand;
    fin_w     = cand ? w_cnt : best_w;
    cnt_up    = (ram_rdata.ref_count == hlbc_pkg::COUNT_MAX) ? ram_rdata.ref_count :
                ram_rdata.ref_count + 8'd1;

    ev_finish = 1'b1;
    ev_we     = 1'b0;
    ev_waddr  = AW'(bkt) * AW'(WAYS) + AW'(w_cnt);
    ev_wdata  = ram_rdata;
    ev_status = hlbc_pkg::STATUS_OK;
    ev_hit    = 1'b0;
    ev_slot   = way_r;
    ev_fill   = 1'b0;

    case (cmd_r) inside
      hlbc_pkg::CMD_GET: begin
        ev_slot = 2'(w_cnt);
        if (rd_hit) begin
          ev_we               = 1'b1;
          ev_wdata.ref_count  = cnt_up;
          ev_wdata.last_use   = now_r;
          ev_wdata.data_valid = 1'b1;
          ev_hit              = 1'b1;
          ev_fill             = !ram_rdata.data_valid;
        end else if (!last) begin
          ev_finish = 1'b0;
        end else if (fin_found) begin
          ev_we    = 1'b1;
          ev_waddr = AW'(bkt) * AW'(WAYS) + AW'(fin_w);
          ev_wdata = '{entry_used: 1'b1, data_valid: 1'b1, tag_device: dev_r,
                       tag_block: blk_r, ref_count: 8'd1, last_use: now_r};
          ev_slot  = 2'(fin_w);
          ev_fill  = 1'b1;
        end else begin
          ev_status = hlbc_pkg::STATUS_NO_FREE;
          ev_slot   = 2'd0;
        end
      end
      hlbc_pkg::CMD_PIN: begin
        ev_we              = 1'b1;
        ev_wdata.ref_count = cnt_up;
      end
      hlbc_pkg::CMD_RELEASE, hlbc_pkg::CMD_UNPIN: begin
        if (ram_rdata.ref_count == 8'd0) begin
          ev_status = hlbc_pkg::STATUS_UNDERFLOW;
        end else begin
          ev_we              = 1'b1;
          ev_wdata.ref_count = ram_rdata.ref_count - 8'd1;
        end
      end
      default: begin
        ev_finish = 1'b1;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      hlbc_pkg::ST_CLEAR: begin
        if (clr_addr == AW'(ENTRIES - 1)) state_next = hlbc_pkg::ST_IDLE;
      end
      hlbc_pkg::ST_IDLE: begin
        if (in_valid) state_next = hlbc_pkg::ST_DIV;
      end
      hlbc_pkg::ST_DIV: begin
        if (div_done) state_next = oor ? hlbc_pkg::ST_FIN : hlbc_pkg::ST_RD;
      end
      hlbc_pkg::ST_RD: begin
        state_next = hlbc_pkg::ST_EV;
      end
      hlbc_pkg::ST_EV: begin
        state_next = ev_finish ? hlbc_pkg::ST_FIN : hlbc_pkg::ST_RD;
      end
      hlbc_pkg::ST_FIN: begin
        if (out_load) state_next = hlbc_pkg::ST_IDLE;
      end
      default: state_next = hlbc_pkg::ST_CLEAR;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    out_load  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = ev_waddr;
    ram_wdata = ev_wdata;
    ram_raddr = AW'(bkt) * AW'(WAYS) + AW'(w_cnt);
    unique case (state)
      hlbc_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      hlbc_pkg::ST_IDLE: begin
        in_stall  = 1'b0;
        div_start = in_valid;
      end
      hlbc_pkg::ST_EV: begin
        ram_we = ev_we;
      end
      hlbc_pkg::ST_FIN: begin
        out_load = !out_valid || !out_stall;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hlbc_pkg::ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == hlbc_pkg::ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= hlbc_pkg::cmd_t'(command);
      dev_r <= device;
      blk_r <= block_number;
      way_r <= way;
      now_r <= now;
    end
    if (state == hlbc_pkg::ST_DIV && div_done) begin
      w_cnt      <= (cmd_r == hlbc_pkg::CMD_GET) ? '0 : WW'(way_r);
      found      <= 1'b0;
      best_time  <= hlbc_pkg::TIME_MAX;
      // way beyond the bucket: answer at once, touch nothing
      res_status <= hlbc_pkg::STATUS_OK;
      res_hit    <= 1'b0;
      res_slot   <= way_r;
      res_fill   <= 1'b0;
    end
    if (state == hlbc_pkg::ST_EV) begin
      if (ev_finish) begin
        res_status <= ev_status;
        res_hit    <= ev_hit;
        res_slot   <= ev_slot;
        res_fill   <= ev_fill;
      end else begin
        w_cnt <= w_cnt + 1'b1;
        if (cand) begin
          found     <= 1'b1;
          best_w    <= w_cnt;
          best_time <= ram_rdata.last_use;
        end
      end
    end
    if (out_load) begin
      status     <= res_status;
      hit        <= res_hit;
      bucket     <= 4'(bkt);
      slot       <= res_slot;
      needs_fill <= res_fill;
    end
  end

  `HLBC_ASSERT(a_no_write_outside_eval, clk, rst, (state == hlbc_pkg::ST_IDLE || state == hlbc_pkg::ST_DIV || state == hlbc_pkg::ST_FIN) |-> !ram_we)
  `HLBC_ASSERT(a_div_done_in_div, clk, rst, div_done |-> state == hlbc_pkg::ST_DIV)
  `HLBC_ASSERT(a_hit_fill_ok, clk, rst, (out_valid && (hit || needs_fill)) |-> status == hlbc_pkg::STATUS_OK)
  `HLBC_ASSERT(a_load_frees_fin, clk, rst, (state == hlbc_pkg::ST_FIN && out_load) |=> out_valid && state == hlbc_pkg::ST_IDLE)
  `HLBC_ASSERT_CLK(a_reset_clears, clk, rst |=> (state == hlbc_pkg::ST_CLEAR && !out_valid))

endmodule
